@@ src/spe_pkg.sv @@
package spe_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int STORE_DEPTH = 4096;

  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int COUNT_W    = ADDR_W + 1;
  localparam int CHAR_W     = 8;
  localparam int PLEN_W     = 6;
  localparam int PIDX_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  // item kinds
  localparam logic [IN_USER_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [IN_USER_W-1:0] KIND_READ  = 2'd1;
  localparam logic [IN_USER_W-1:0] KIND_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3  = 3'd4;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } ram_req_t;

endpackage

@@ src/spe_ram.sv @@
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/spe_pattern.sv @@
module spe_pattern (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [spe_pkg::PIDX_W-1:0]         pat_sel,
  output logic [spe_pkg::PLEN_W-1:0]         eff_len,
  output logic [spe_pkg::CHAR_W-1:0]         pat_char
);

  logic [spe_pkg::PLEN_W-1:0]     plen;
  logic [spe_pkg::CFG_DATA_W-1:0] words [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= spe_pkg::PLEN_W'(1);
      words[0] <= '0;
      words[1] <= '0;
      words[2] <= '0;
      words[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spe_pkg::REG_PLEN: plen     <= cfg_data[spe_pkg::PLEN_W-1:0];
        spe_pkg::REG_PAT0: words[0] <= cfg_data;
        spe_pkg::REG_PAT1: words[1] <= cfg_data;
        spe_pkg::REG_PAT2: words[2] <= cfg_data;
        spe_pkg::REG_PAT3: words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_len = (plen > spe_pkg::PLEN_W'(spe_pkg::PATTERN_MAX)) ?
                   spe_pkg::PLEN_W'(spe_pkg::PATTERN_MAX) : plen;

  assign pat_char = words[pat_sel[4:3]][{pat_sel[2:0], 3'b000} +: spe_pkg::CHAR_W];

endmodule

@@ src/spe_ctrl.sv @@
module spe_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [spe_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [spe_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [spe_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic [spe_pkg::PLEN_W-1:0]         eff_len,
  input  logic [spe_pkg::CHAR_W-1:0]         pat_char,
  output logic [spe_pkg::PIDX_W-1:0]         pat_sel,
  output spe_pkg::ram_req_t                  ram_req,
  input  logic [spe_pkg::CHAR_W-1:0]         ram_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_WR   = 5'b00100,
    ST_RD   = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                          state;
  logic [spe_pkg::COUNT_W-1:0]     count;
  logic [spe_pkg::CHAR_W-1:0]      ch;
  logic [spe_pkg::ADDR_W-1:0]      base;
  logic [spe_pkg::PIDX_W-1:0]      last_k;
  logic [spe_pkg::PIDX_W-1:0]      iss_k;
  logic                            iss_done;
  logic                            cv;
  logic [spe_pkg::PIDX_W-1:0]      cmp_k;
  logic [spe_pkg::CHAR_W-1:0]      res_char;
  logic                            res_removed;
  logic [spe_pkg::COUNT_W-1:0]     res_len;
  logic                            res_over;

  logic [spe_pkg::IN_USER_W-1:0]   in_kind;
  logic [spe_pkg::CHAR_W-1:0]      in_ch;
  logic [spe_pkg::ADDR_W-1:0]      in_idx;
  logic                            accept;
  logic                            full;
  logic [spe_pkg::COUNT_W-1:0]     cnt_inc;
  logic                            too_short;
  logic [spe_pkg::CHAR_W-1:0]      cmp_data;
  logic                            eq;
  logic                            cmp_end;
  logic                            slot;

  assign in_kind = s_tuser;
  assign in_ch   = s_tdata[7:0];
  assign in_idx  = s_tdata[19:8];

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == spe_pkg::COUNT_W'(spe_pkg::STORE_DEPTH));
  assign cnt_inc   = count + spe_pkg::COUNT_W'(1);
  assign too_short = (cnt_inc < spe_pkg::COUNT_W'(eff_len));

  // slot k is issued in the cycle before it is compared; the newest char is not in RAM yet
  assign pat_sel  = cmp_k;
  assign cmp_data = (cmp_k == last_k) ? ch : ram_rdata;
  assign eq       = (cmp_data == pat_char);
  assign cmp_end  = cv && (!eq || (cmp_k == last_k));
  assign slot     = (state == ST_CMP) && !iss_done && !cmp_end;

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.addr  = base + spe_pkg::ADDR_W'(iss_k);
    ram_req.wdata = ch;
    case (state)
      ST_IDLE: ram_req.addr = in_idx;
      ST_CMP: begin
        if (cmp_end) begin
          ram_req.we   = 1'b1;
          ram_req.addr = count[spe_pkg::ADDR_W-1:0];
        end
      end
      ST_WR: begin
        ram_req.we   = 1'b1;
        ram_req.addr = count[spe_pkg::ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_char    <= '0;
            res_removed <= 1'b0;
            res_over    <= 1'b0;
            res_len     <= count;
            ch          <= in_ch;
            case (in_kind)
              spe_pkg::KIND_PUSH: begin
                if (full) begin
                  res_over <= 1'b1;
                  state    <= ST_DONE;
                end else if ((eff_len == '0) || too_short) begin
                  state <= ST_WR;
                end else begin
                  base     <= spe_pkg::ADDR_W'(cnt_inc - spe_pkg::COUNT_W'(eff_len));
                  last_k   <= spe_pkg::PIDX_W'(eff_len - spe_pkg::PLEN_W'(1));
                  iss_k    <= '0;
                  iss_done <= 1'b0;
                  cv       <= 1'b0;
                  state    <= ST_CMP;
                end
              end
              spe_pkg::KIND_READ: begin
                if ({1'b0, in_idx} < count) begin
                  state <= ST_RD;
                end else begin
                  res_over <= 1'b1;
                  state    <= ST_DONE;
                end
              end
              spe_pkg::KIND_CLEAR: begin
                count   <= '0;
                res_len <= '0;
                state   <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CMP: begin
          cv <= slot;
          if (slot) begin
            cmp_k <= iss_k;
            if (iss_k == last_k) begin
              iss_done <= 1'b1;
            end else begin
              iss_k <= iss_k + spe_pkg::PIDX_W'(1);
            end
          end
          if (cmp_end) begin
            // eq here means the last slot matched too: whole tail is the pattern
            if (eq) begin
              count       <= {1'b0, base};
              res_len     <= {1'b0, base};
              res_removed <= 1'b1;
            end else begin
              count   <= cnt_inc;
              res_len <= cnt_inc;
            end
            state <= ST_DONE;
          end
        end
        ST_WR: begin
          count   <= cnt_inc;
          res_len <= cnt_inc;
          state   <= ST_DONE;
        end
        ST_RD: begin
          res_char <= ram_rdata;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, res_over, res_len, res_removed, res_char};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/streaming_pattern_eraser.sv @@
// channel   dir  fields (lowest bit up)
// s_*       in   tuser: kind[1:0]; tdata: char_in[7:0], read_index[19:8], zero[23:20]
// m_*       out  tdata: char_out[7:0], removed[8], text_length[21:9], overflow[22], zero[23]
// cfg_*     in   cfg_index selects register, cfg_data carries it, cfg_we writes it
//
// Push: writes the character with no compare when nothing is compared; otherwise one
// store read per tail character of an n-character pattern on the single RAM port,
// plus the write, ending early on a mismatch. Read: one store read. Clear, push onto
// a full store, read beyond the length and the unused kind go straight to the result.
// One item at a time; a result waiting in the output register does not block the
// next accept, only the hand-over of the following result.
// Synchronous reset empties the text and sets pattern length 1; no clearing pass.
module streaming_pattern_eraser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // char_in[7:0], read_index[19:8], zero pad
  input  logic [spe_pkg::IN_DATA_W-1:0]   s_tdata,
  // kind[1:0]
  input  logic [spe_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // char_out[7:0], removed[8], text_length[21:9], overflow[22], zero pad
  output logic [spe_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic [spe_pkg::PLEN_W-1:0] eff_len;
  logic [spe_pkg::CHAR_W-1:0] pat_char;
  logic [spe_pkg::PIDX_W-1:0] pat_sel;
  spe_pkg::ram_req_t          ram_req;
  logic [spe_pkg::CHAR_W-1:0] ram_rdata;

  spe_pattern u_pattern (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_sel   (pat_sel),
    .eff_len   (eff_len),
    .pat_char  (pat_char)
  );

  spe_ram #(
    .WIDTH (spe_pkg::CHAR_W),
    .DEPTH (spe_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  spe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .eff_len   (eff_len),
    .pat_char  (pat_char),
    .pat_sel   (pat_sel),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

@@ src/spe_checker.sv @@
module spe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spe_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[21:9] <= spe_pkg::COUNT_W'(spe_pkg::STORE_DEPTH))
    else $error("text length beyond store depth");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[22]))
    else $error("removed and overflow both set");

  a_rm_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == '0)
    else $error("push result carries a character");

endmodule

bind streaming_pattern_eraser spe_checker u_chk (.*);

@@ bench/tb_streaming_pattern_eraser.sv @@
module tb_streaming_pattern_eraser;

  localparam int IN_USER_W   = spe_pkg::IN_USER_W;
  localparam int IN_DATA_W   = spe_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = spe_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W   = spe_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = spe_pkg::CFG_DATA_W;
  localparam int COUNT_W     = spe_pkg::COUNT_W;
  localparam int CHAR_W      = spe_pkg::CHAR_W;
  localparam int ADDR_W      = spe_pkg::ADDR_W;
  localparam int PLEN_W      = spe_pkg::PLEN_W;
  localparam int STORE_DEPTH = spe_pkg::STORE_DEPTH;
  localparam logic [IN_USER_W-1:0] KIND_PUSH  = spe_pkg::KIND_PUSH;
  localparam logic [IN_USER_W-1:0] KIND_READ  = spe_pkg::KIND_READ;
  localparam logic [IN_USER_W-1:0] KIND_CLEAR = spe_pkg::KIND_CLEAR;
  localparam logic [CFG_IDX_W-1:0] REG_PLEN   = spe_pkg::REG_PLEN;
  localparam logic [CFG_IDX_W-1:0] REG_PAT0   = spe_pkg::REG_PAT0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1   = spe_pkg::REG_PAT1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2   = spe_pkg::REG_PAT2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3   = spe_pkg::REG_PAT3;

  localparam int QUIET_LIMIT  = 5000;
  localparam int END_CYCLES   = 40;
  localparam int PHASES       = 13;
  localparam int PHASE_ITEMS  = 127;
  localparam int DIR_ROWS     = 30;
  localparam logic [IN_USER_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic                overflow;
    logic [COUNT_W-1:0]  text_length;
    logic                removed;
    logic [CHAR_W-1:0]   char_out;
  } result_t;

  typedef enum logic [1:0] {ACT_CHECK, ACT_ITEM, ACT_WRITE} row_act_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_act_t               act;
    logic [CFG_IDX_W-1:0]   reg_sel;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [IN_USER_W-1:0]   kind;
    logic [CHAR_W-1:0]      ch;
    logic [ADDR_W-1:0]      idx;
    result_t                want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // char_in[7:0], read_index[19:8], zero pad
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  // kind[1:0]
  logic [IN_USER_W-1:0]   s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // char_out[7:0], removed[8], text_length[21:9], overflow[22], zero pad
  logic [OUT_DATA_W-1:0]  m_tdata;

  streaming_pattern_eraser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // own copy of the eraser state
  logic [CHAR_W-1:0]      text_mem [STORE_DEPTH];
  int                     text_len = 0;
  logic [PLEN_W-1:0]      pat_len_reg = 6'd1;
  logic [CFG_DATA_W-1:0]  pat_word [4] = '{64'd0, 64'd0, 64'd0, 64'd0};

  result_t                outcome_q [$];
  logic [CHAR_W-1:0]      plan_chars [$];
  logic [CHAR_W-1:0]      alpha [2] = '{8'h00, 8'hFF};
  int                     src_idle_pct = 0;
  int                     sink_stall_pct = 0;
  int                     hold_left = 0;
  int                     mismatches = 0;
  int                     quiet_cycles = 0;
  result_t                seen_beat;
  result_t                due_beat;

  int phase_len [PHASES] = '{2, 1, 3, 0, 8, 32, 5, 63, 16, 4, 33, 9, 31};

  row_t dir_rows [DIR_ROWS] = '{
    // after reset: length 1, pattern byte 0x00
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_READ,  8'h00, 12'h000, {1'b1, 13'd0, 1'b0, 8'h00}},
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_PUSH,  8'h00, 12'h000, {1'b0, 13'd0, 1'b1, 8'h00}},
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_PUSH,  8'hFF, 12'h000, {1'b0, 13'd1, 1'b0, 8'h00}},
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_READ,  8'h00, 12'h000, {1'b0, 13'd1, 1'b0, 8'hFF}},
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_READ,  8'h00, 12'hFFF, {1'b1, 13'd1, 1'b0, 8'h00}},
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_SPARE, 8'hFF, 12'hFFF, {1'b0, 13'd1, 1'b0, 8'h00}},
    '{ACT_CHECK, REG_PLEN, 64'd0, KIND_CLEAR, 8'hFF, 12'hFFF, {1'b0, 13'd0, 1'b0, 8'h00}},
    '{ACT_WRITE, REG_PAT0, 64'h0000_0000_0063_6261, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    '{ACT_WRITE, REG_PLEN, 64'd3, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    // nested "abc": inner one goes first, then the outer one closes
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h61, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h62, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h61, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h62, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h63, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h63, 12'h000, 23'd0},
    // stack shorter than the pattern
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h62, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h63, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_READ,  8'h00, 12'h001, 23'd0},
    '{ACT_WRITE, REG_PLEN, 64'd0, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h61, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h62, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h63, 12'h000, 23'd0},
    '{ACT_WRITE, REG_PAT0, 64'hFFFF_FFFF_FFFF_FFFF, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    '{ACT_WRITE, REG_PAT1, 64'h8000_0000_0000_0001, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    '{ACT_WRITE, REG_PAT2, 64'h0123_4567_89AB_CDEF, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    '{ACT_WRITE, REG_PAT3, 64'hFEDC_BA98_7654_3210, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    // upper bits of the length write are don't-care
    '{ACT_WRITE, REG_PLEN, 64'hFFFF_FFFF_FFFF_FFC1, KIND_PUSH, 8'h00, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'hFF, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_PUSH,  8'h00, 12'h000, 23'd0},
    '{ACT_ITEM,  REG_PLEN, 64'd0, KIND_READ,  8'h00, 12'h005, 23'd0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_len();
    return (pat_len_reg > 6'd32) ? 32 : int'(pat_len_reg);
  endfunction

  function automatic logic [CHAR_W-1:0] pat_char(input int k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    if ($urandom_range(1) != 0) return 8'($urandom);
    return alpha[$urandom_range(1)];
  endfunction

  task automatic erase_step(input logic [IN_USER_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input logic [ADDR_W-1:0] idx, output result_t r);
    int  n;
    int  k;
    bit  hit;
    r = '0;
    case (kind)
      KIND_PUSH: begin
        if (text_len >= STORE_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          text_mem[text_len] = ch;
          text_len++;
          n = eff_len();
          hit = (n != 0) && (text_len >= n);
          for (k = 0; k < n && hit; k++)
            if (text_mem[text_len - n + k] != pat_char(k)) hit = 1'b0;
          if (hit) begin
            text_len -= n;
            r.removed = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (int'(idx) < text_len) r.char_out = text_mem[idx];
        else r.overflow = 1'b1;
      end
      KIND_CLEAR: text_len = 0;
      default: ;
    endcase
    r.text_length = COUNT_W'(text_len);
  endtask

  task automatic offer(input logic [IN_USER_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                       input logic [ADDR_W-1:0] idx, input bit fixed, input result_t fixed_val);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, idx, ch};
    do @(posedge clk); while (!s_tready);
    erase_step(kind, ch, idx, r);
    outcome_q.insert(outcome_q.size(), fixed ? fixed_val : r);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding beat; always waits on the clock before returning
  task automatic quiesce();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outcome_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_PLEN) pat_len_reg = v[PLEN_W-1:0];
    else pat_word[sel - REG_PAT0] = v;
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SRC:  begin src_idle_pct = 84; sink_stall_pct = 0;  end
      IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 84; end
      default:   begin src_idle_pct = 34; sink_stall_pct = 34; end
    endcase
  endtask

  task automatic load_pattern(input int plen_val);
    logic [CFG_DATA_W-1:0] w;
    int sel;
    int b;
    int k;
    sel = $urandom_range(2);
    alpha[0] = (sel == 2) ? 8'h00 : 8'($urandom);
    alpha[1] = (sel == 2) ? 8'hFF : 8'($urandom);
    for (b = 0; b < 4; b++) begin
      for (k = 0; k < 8; k++)
        w[k * 8 +: 8] = (sel == 0) ? 8'($urandom) : alpha[$urandom_range(1)];
      write_reg(REG_PAT0 + CFG_IDX_W'(b), w);
    end
    write_reg(REG_PLEN, {32'($urandom), 26'($urandom), PLEN_W'(plen_val)});
    plan_chars.delete();
  endtask

  // queue up characters: mostly whole (often nested) patterns, some broken ones and noise
  task automatic refill_plan();
    int n;
    int cut;
    int sel;
    int k;
    n = eff_len();
    if (n == 0) n = 4;
    sel = $urandom_range(9);
    if (sel < 6) begin
      cut = $urandom_range(n);
      for (k = 0; k < cut; k++) plan_chars.insert(plan_chars.size(), pat_char(k));
      if ($urandom_range(1) != 0)
        for (k = 0; k < n; k++) plan_chars.insert(plan_chars.size(), pat_char(k));
      for (k = cut; k < n; k++) plan_chars.insert(plan_chars.size(), pat_char(k));
    end else if (sel < 8) begin
      cut = $urandom_range(n - 1);
      for (k = 0; k < cut; k++) plan_chars.insert(plan_chars.size(), pat_char(k));
      plan_chars.insert(plan_chars.size(), noise_char());
    end else begin
      repeat ($urandom_range(1, 3)) plan_chars.insert(plan_chars.size(), noise_char());
    end
  endtask

  task automatic random_item(output logic [IN_USER_W-1:0] kind, output logic [CHAR_W-1:0] ch,
                             output logic [ADDR_W-1:0] idx);
    int r;
    r   = $urandom_range(99);
    ch  = 8'($urandom);
    idx = 12'($urandom);
    if (r < 7) begin
      kind = KIND_READ;
      if (text_len > 0 && $urandom_range(3) != 0) idx = 12'($urandom_range(text_len - 1));
    end else if (r < 9) begin
      kind = KIND_CLEAR;
    end else if (r < 10) begin
      kind = KIND_SPARE;
    end else begin
      kind = KIND_PUSH;
      if (plan_chars.size() == 0) refill_plan();
      ch = plan_chars.pop_front();
    end
  endtask

  // receiver: random stalls, plus a counted hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_beat = m_tdata[OUT_DATA_W-2:0];
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat %h", $time, seen_beat);
      end else begin
        due_beat = outcome_q.pop_front();
        if (seen_beat.char_out !== due_beat.char_out || seen_beat.removed !== due_beat.removed ||
            seen_beat.text_length !== due_beat.text_length ||
            seen_beat.overflow !== due_beat.overflow) begin
          mismatches++;
          $display("%0t: expected char %h removed %b len %0d ovf %b, got char %h removed %b len %0d ovf %b",
                   $time, due_beat.char_out, due_beat.removed, due_beat.text_length,
                   due_beat.overflow, seen_beat.char_out, seen_beat.removed,
                   seen_beat.text_length, seen_beat.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("streaming_pattern_eraser: mismatch");
      $finish;
    end
  end

  initial begin
    logic [IN_USER_W-1:0]   kind;
    logic [CHAR_W-1:0]      ch;
    logic [ADDR_W-1:0]      idx;
    row_t                   row;
    int                     i;
    int                     p;
    int                     j;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idle(IDLE_BOTH);
    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.act == ACT_WRITE) begin
        quiesce();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        offer(row.kind, row.ch, row.idx, row.act == ACT_CHECK, row.want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      quiesce();
      set_idle(idle_mode_t'(p % 4));
      load_pattern(phase_len[p]);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        random_item(kind, ch, idx);
        offer(kind, ch, idx, 1'b0, '0);
        // long receiver hold-off while the sender keeps offering
        if (p == 4 && j == 30) hold_left = 400;
        if (p == 5 && j == 60) quiesce();
      end
    end

    quiesce();
    set_idle(IDLE_BOTH);
    offer(KIND_READ, 8'h00, 12'hFFF, 1'b0, '0);
    offer(KIND_CLEAR, 8'h00, 12'h000, 1'b0, '0);

    quiesce();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("streaming_pattern_eraser: match");
    end else begin
      $display("streaming_pattern_eraser: mismatch");
    end
    $finish;
  end

endmodule

@@ streaming_pattern_eraser.f @@
src/spe_pkg.sv
src/spe_ram.sv
src/spe_pattern.sv
src/spe_ctrl.sv
src/streaming_pattern_eraser.sv
src/spe_checker.sv
bench/tb_streaming_pattern_eraser.sv
